[rtl/ptvc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ptvc_pkg;

  // command freshness limit in ticks
  localparam logic [7:0] TIMEOUT_TICKS = 8'd25;

  // configuration register indexes
  localparam logic [2:0] REG_KP_GAIN           = 3'd0;
  localparam logic [2:0] REG_SPEED_LIMIT       = 3'd1;
  localparam logic [2:0] REG_ERROR_THRESHOLD   = 3'd2;
  localparam logic [2:0] REG_LOW_SPEED_THRESH  = 3'd3;
  localparam logic [2:0] REG_SEVERE_THRESHOLD  = 3'd4;
  localparam logic [2:0] REG_HOLD_TICKS        = 3'd5;
  localparam logic [2:0] REG_COOLDOWN_TICKS    = 3'd6;
  localparam logic [2:0] REG_BRAKE_TICKS       = 3'd7;

  // register reset values
  localparam logic [15:0] RST_KP_GAIN          = 16'd640;
  localparam logic [23:0] RST_SPEED_LIMIT      = 24'd131072;
  localparam logic [23:0] RST_ERROR_THRESHOLD  = 24'd78643;
  localparam logic [23:0] RST_LOW_SPEED_THRESH = 24'd16384;
  localparam logic [23:0] RST_SEVERE_THRESHOLD = 24'd196608;
  localparam logic [15:0] RST_HOLD_TICKS       = 16'd100;
  localparam logic [15:0] RST_COOLDOWN_TICKS   = 16'd200;
  localparam logic [15:0] RST_BRAKE_TICKS      = 16'd40;

  // output mode codes
  localparam logic [1:0] MODE_TRACK = 2'd0;
  localparam logic [1:0] MODE_IDLE  = 2'd1;
  localparam logic [1:0] MODE_BRAKE = 2'd2;

  localparam logic [15:0] SAT16 = 16'hFFFF;

endpackage
`default_nettype wire

[rtl/ptvc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// input item channel
interface ptvc_cmd_if;
  logic               valid;
  logic               ready;
  logic               inputs_valid;
  logic [7:0]         command_age;
  logic signed [31:0] measured_x;
  logic signed [31:0] measured_y;
  logic signed [31:0] measured_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [31:0] feedforward_x;
  logic signed [31:0] feedforward_y;
  logic signed [31:0] feedforward_z;
  logic signed [31:0] heading;
  modport source (output valid, inputs_valid, command_age, measured_x, measured_y,
                  measured_z, target_x, target_y, target_z, feedforward_x,
                  feedforward_y, feedforward_z, heading, input ready);
  modport sink (input valid, inputs_valid, command_age, measured_x, measured_y,
                measured_z, target_x, target_y, target_z, feedforward_x,
                feedforward_y, feedforward_z, heading, output ready);
endinterface

// result item channel
interface ptvc_res_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] drive_x;
  logic signed [24:0] drive_y;
  logic signed [24:0] drive_z;
  logic signed [31:0] heading_out;
  logic               loss_flag;
  logic [1:0]         mode;
  modport source (output valid, drive_x, drive_y, drive_z, heading_out, loss_flag,
                  mode, input ready);
  modport sink (input valid, drive_x, drive_y, drive_z, heading_out, loss_flag,
                mode, output ready);
endinterface

// configuration write channel
interface ptvc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/position_tracking_velocity_controller_unit.sv]
// a stale or invalid item goes straight to the result; a tracking item takes a
// pre-shift of s = 0..10 steps, and when the speed limit applies (or s > 0) also a
// 32-step square root and three 25-step divides, products from one shared multiplier;
// one item at a time: a new item is taken only once the last result has gone to the
// output register, so a held result stalls the next item;
// synchronous active-high reset restores the register reset values and clears the timers
`timescale 1ns / 1ps
`default_nettype none
module position_tracking_velocity_controller_unit (
  input wire logic clk,
  input wire logic rst,
  ptvc_cmd_if.sink   cmd,
  ptvc_res_if.source result,
  ptvc_cfg_if.sink   cfg
);
  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQW, S_DEC, S_GAIN, S_GAINW, S_NORM, S_MAG, S_MAGW,
    S_CHK, S_SQRTW, S_QM, S_QMW, S_DIVW, S_DONE
  } state_t;

  state_t state;
  logic [3:0] k;

  // configuration
  logic [15:0] kp_gain;
  logic [23:0] speed_limit, error_threshold, low_speed_threshold, severe_threshold;
  logic [15:0] hold_ticks, cooldown_ticks, brake_ticks;

  // detector state
  logic        armed, hold_active, recovered_once;
  logic [15:0] hold_count, since_recovery, brake_remaining;

  // item data
  logic        dneg [3];
  logic [32:0] magd [3];
  logic [31:0] capd [3];
  logic [31:0] capf [3];
  logic signed [31:0] ffv [3];
  logic signed [31:0] head;
  logic [63:0] e2, f2, n2;
  logic [47:0] thr2, ls2, sv2, lim2;
  logic        vneg [3];
  logic [42:0] vmag [3];
  logic [42:0] m;
  logic [3:0]  s;
  logic [32:0] norm;

  // result being built
  logic signed [24:0] res_drive [3];
  logic signed [31:0] res_heading;
  logic               res_lost;
  logic [1:0]         res_mode;

  // shared units
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  logic        sq_start, sq_done;
  logic [32:0] sq_root;
  logic        dv_start, dv_done;
  logic [24:0] dv_quo;
  logic [56:0] dv_num;
  logic [33:0] dv_den;

  ptvc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
  ptvc_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .radicand(n2),
                    .done(sq_done), .root(sq_root));
  ptvc_div u_div (.clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
                  .done(dv_done), .quo(dv_quo));

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // input side decode
  logic        stale;
  logic signed [32:0] din [3];
  logic [32:0] dmag [3];
  logic signed [31:0] ffin [3];
  logic [31:0] ffmag [3];
  logic [15:0] hc_aged, sr_aged, br_aged;

  assign stale = !cmd.inputs_valid || (cmd.command_age > ptvc_pkg::TIMEOUT_TICKS);
  assign din[0] = {cmd.target_x[31], cmd.target_x} - {cmd.measured_x[31], cmd.measured_x};
  assign din[1] = {cmd.target_y[31], cmd.target_y} - {cmd.measured_y[31], cmd.measured_y};
  assign din[2] = {cmd.target_z[31], cmd.target_z} - {cmd.measured_z[31], cmd.measured_z};
  assign ffin[0] = cmd.feedforward_x;
  assign ffin[1] = cmd.feedforward_y;
  assign ffin[2] = cmd.feedforward_z;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i]  = din[i][32] ? 33'(-din[i]) : 33'(din[i]);
      ffmag[i] = ffin[i][31] ? 32'(-ffin[i]) : 32'(ffin[i]);
    end
  end

  // timers age at every item; a stale item clears the hold count instead
  assign hc_aged = (hold_active && hold_count != ptvc_pkg::SAT16) ?
                   hold_count + 16'd1 : hold_count;
  assign sr_aged = (recovered_once && since_recovery != ptvc_pkg::SAT16) ?
                   since_recovery + 16'd1 : since_recovery;
  assign br_aged = (brake_remaining != 16'd0) ? brake_remaining - 16'd1 : 16'd0;

  // loss detector decision
  logic rearm, cand, lose_ok, lose;
  logic [15:0] brake_after;
  assign rearm   = e2 <= {18'd0, thr2[47:2]};
  assign cand    = (e2 > {16'd0, thr2}) &&
                   ((f2 < {16'd0, ls2}) || (e2 > {16'd0, sv2}));
  assign lose_ok = hold_active && (hold_count >= hold_ticks) &&
                   (!recovered_once || since_recovery >= cooldown_ticks);
  assign lose    = !rearm && cand && armed && lose_ok;
  assign brake_after = lose ? brake_ticks : brake_remaining;

  // velocity from the gain product
  logic [40:0] tmag;
  logic signed [43:0] vsum;
  logic [42:0] vsmag;
  logic [42:0] amag_full;
  logic [30:0] amag;
  assign tmag  = 41'((prod[48:0] + 49'd128) >> 8);
  assign vsum  = 44'(ffv[k[1:0]]) + (dneg[k[1:0]] ? -44'(tmag) : 44'(tmag));
  assign vsmag = vsum[43] ? 43'(-vsum) : 43'(vsum);
  assign amag_full = vmag[k[1:0]] >> s;
  assign amag  = amag_full[30:0];

  // scaled component
  logic [23:0] qcap;
  assign qcap = (dv_quo > {1'b0, speed_limit}) ? speed_limit : dv_quo[23:0];

  assign sq_start = (state == S_CHK) && ((s != 4'd0) || (n2 > {16'd0, lim2}));
  assign dv_start = (state == S_QMW);
  assign dv_num   = {prod[54:0], 1'b0} + {24'd0, norm};
  assign dv_den   = {norm, 1'b0};

  // multiplier operand select
  always_comb begin
    mul_a = 33'd0;
    mul_b = 32'd0;
    case (state)
      S_SQ: begin
        if (k < 4'd3) begin
          mul_a = {1'b0, capd[k[1:0]]};
          mul_b = capd[k[1:0]];
        end else if (k < 4'd6) begin
          mul_a = {1'b0, capf[2'(k - 4'd3)]};
          mul_b = capf[2'(k - 4'd3)];
        end else if (k == 4'd6) begin
          mul_a = {9'd0, error_threshold};
          mul_b = {8'd0, error_threshold};
        end else if (k == 4'd7) begin
          mul_a = {9'd0, low_speed_threshold};
          mul_b = {8'd0, low_speed_threshold};
        end else begin
          mul_a = {9'd0, severe_threshold};
          mul_b = {8'd0, severe_threshold};
        end
      end
      S_GAIN: begin
        mul_a = magd[k[1:0]];
        mul_b = {16'd0, kp_gain};
      end
      S_MAG: begin
        if (k < 4'd3) begin
          mul_a = {2'd0, amag};
          mul_b = {1'b0, amag};
        end else begin
          mul_a = {9'd0, speed_limit};
          mul_b = {8'd0, speed_limit};
        end
      end
      S_QM: begin
        mul_a = {2'd0, amag};
        mul_b = {8'd0, speed_limit};
      end
      default: begin
        mul_a = 33'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain             <= ptvc_pkg::RST_KP_GAIN;
      speed_limit         <= ptvc_pkg::RST_SPEED_LIMIT;
      error_threshold     <= ptvc_pkg::RST_ERROR_THRESHOLD;
      low_speed_threshold <= ptvc_pkg::RST_LOW_SPEED_THRESH;
      severe_threshold    <= ptvc_pkg::RST_SEVERE_THRESHOLD;
      hold_ticks          <= ptvc_pkg::RST_HOLD_TICKS;
      cooldown_ticks      <= ptvc_pkg::RST_COOLDOWN_TICKS;
      brake_ticks         <= ptvc_pkg::RST_BRAKE_TICKS;
    end else if (cfg.valid) begin
      case (cfg.index)
        ptvc_pkg::REG_KP_GAIN:          kp_gain             <= cfg.data[15:0];
        ptvc_pkg::REG_SPEED_LIMIT:      speed_limit         <= cfg.data;
        ptvc_pkg::REG_ERROR_THRESHOLD:  error_threshold     <= cfg.data;
        ptvc_pkg::REG_LOW_SPEED_THRESH: low_speed_threshold <= cfg.data;
        ptvc_pkg::REG_SEVERE_THRESHOLD: severe_threshold    <= cfg.data;
        ptvc_pkg::REG_HOLD_TICKS:       hold_ticks          <= cfg.data[15:0];
        ptvc_pkg::REG_COOLDOWN_TICKS:   cooldown_ticks      <= cfg.data[15:0];
        ptvc_pkg::REG_BRAKE_TICKS:      brake_ticks         <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      k               <= 4'd0;
      armed           <= 1'b1;
      hold_active     <= 1'b0;
      hold_count      <= 16'd0;
      recovered_once  <= 1'b0;
      since_recovery  <= 16'd0;
      brake_remaining <= 16'd0;
      result.valid    <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_DONE) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            since_recovery  <= sr_aged;
            brake_remaining <= br_aged;
            res_drive[0] <= '0;
            res_drive[1] <= '0;
            res_drive[2] <= '0;
            res_lost     <= 1'b0;
            if (stale) begin
              hold_active <= 1'b0;
              hold_count  <= 16'd0;
              res_heading <= '0;
              res_mode    <= ptvc_pkg::MODE_IDLE;
              state       <= S_DONE;
            end else begin
              hold_count <= hc_aged;
              for (int i = 0; i < 3; i++) begin
                dneg[i] <= din[i][32];
                magd[i] <= dmag[i];
                capd[i] <= (dmag[i] > 33'h0_8000_0000) ? 32'h8000_0000 : dmag[i][31:0];
                capf[i] <= ffmag[i];
                ffv[i]  <= ffin[i];
              end
              head  <= cmd.heading;
              e2    <= 64'd0;
              f2    <= 64'd0;
              k     <= 4'd0;
              state <= S_SQ;
            end
          end
        end
        S_SQ: state <= S_SQW;
        // accumulate squares and threshold squares
        S_SQW: begin
          if (k < 4'd3) begin
            e2 <= e2 + prod[63:0];
          end else if (k < 4'd6) begin
            f2 <= f2 + prod[63:0];
          end else if (k == 4'd6) begin
            thr2 <= prod[47:0];
          end else if (k == 4'd7) begin
            ls2 <= prod[47:0];
          end else begin
            sv2 <= prod[47:0];
          end
          if (k == 4'd8) begin
            state <= S_DEC;
          end else begin
            k     <= k + 4'd1;
            state <= S_SQ;
          end
        end
        // loss detector update
        S_DEC: begin
          if (rearm) begin
            hold_active <= 1'b0;
            hold_count  <= 16'd0;
            armed       <= 1'b1;
          end else if (cand && armed) begin
            if (!hold_active) begin
              hold_active <= 1'b1;
              hold_count  <= 16'd0;
            end else if (lose_ok) begin
              recovered_once  <= 1'b1;
              since_recovery  <= 16'd0;
              hold_active     <= 1'b0;
              hold_count      <= 16'd0;
              armed           <= 1'b0;
              brake_remaining <= brake_ticks;
            end
          end else if (!cand) begin
            hold_active <= 1'b0;
            hold_count  <= 16'd0;
          end
          res_lost    <= lose;
          res_heading <= head;
          if (brake_after != 16'd0) begin
            res_mode <= ptvc_pkg::MODE_BRAKE;
            state    <= S_DONE;
          end else begin
            m     <= 43'd0;
            k     <= 4'd0;
            state <= S_GAIN;
          end
        end
        S_GAIN: state <= S_GAINW;
        // feedforward plus rounded gain term, track largest magnitude
        S_GAINW: begin
          vneg[k[1:0]] <= vsum[43];
          vmag[k[1:0]] <= vsmag;
          if (vsmag > m) begin
            m <= vsmag;
          end
          if (k == 4'd2) begin
            s     <= 4'd0;
            state <= S_NORM;
          end else begin
            k     <= k + 4'd1;
            state <= S_GAIN;
          end
        end
        // common right shift until every magnitude is below 2^31
        S_NORM: begin
          if (m[42:31] != 12'd0) begin
            m <= m >> 1;
            s <= s + 4'd1;
          end else begin
            n2    <= 64'd0;
            k     <= 4'd0;
            state <= S_MAG;
          end
        end
        S_MAG: state <= S_MAGW;
        S_MAGW: begin
          if (k < 4'd3) begin
            n2    <= n2 + prod[63:0];
            k     <= k + 4'd1;
            state <= S_MAG;
          end else begin
            lim2  <= prod[47:0];
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (sq_start) begin
            state <= S_SQRTW;
          end else begin
            for (int i = 0; i < 3; i++) begin
              res_drive[i] <= vneg[i] ? 25'(-vmag[i]) : 25'(vmag[i]);
            end
            res_mode <= ptvc_pkg::MODE_TRACK;
            state    <= S_DONE;
          end
        end
        S_SQRTW: begin
          if (sq_done) begin
            norm  <= sq_root;
            k     <= 4'd0;
            state <= S_QM;
          end
        end
        S_QM: state <= S_QMW;
        S_QMW: state <= S_DIVW;
        // rounded scaled component, capped at the limit
        S_DIVW: begin
          if (dv_done) begin
            res_drive[k[1:0]] <= vneg[k[1:0]] ? -25'(qcap) : 25'(qcap);
            if (k == 4'd2) begin
              res_mode <= ptvc_pkg::MODE_TRACK;
              state    <= S_DONE;
            end else begin
              k     <= k + 4'd1;
              state <= S_QM;
            end
          end
        end
        // hand the result to the output register
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid       <= 1'b1;
            result.drive_x     <= res_drive[0];
            result.drive_y     <= res_drive[1];
            result.drive_z     <= res_drive[2];
            result.heading_out <= res_heading;
            result.loss_flag   <= res_lost;
            result.mode        <= res_mode;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/ptvc_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared multiplier with registered product
module ptvc_mul (
  input  wire logic        clk,
  input  wire logic [32:0] a,
  input  wire logic [31:0] b,
  output logic      [64:0] p
);
  always_ff @(posedge clk) begin
    p <= {32'd0, a} * {33'd0, b};
  end
endmodule
`default_nettype wire

[rtl/ptvc_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// bit-pair integer square root, one step per cycle
module ptvc_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic      [32:0] root
);
  logic [63:0] n;
  logic [63:0] r;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root  = r[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n    <= radicand;
        r    <= 64'd0;
        bitv <= 64'h4000_0000_0000_0000;
        busy <= 1'b1;
      end else if (busy) begin
        // one result bit per step
        if (n >= trial) begin
          n <= n - trial;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/ptvc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, 25 quotient bits, one per cycle
module ptvc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [56:0] num,
  input  wire logic [33:0] den,
  output logic             done,
  output logic      [24:0] quo
);
  logic [56:0] rem;
  logic [57:0] dsh;
  logic [4:0]  cnt;
  logic        busy;
  logic        fits;

  assign fits = {1'b0, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= {den, 24'd0};
        cnt  <= 5'd24;
        quo  <= 25'd0;
        busy <= 1'b1;
      end else if (busy) begin
        // trial subtract of the shifted divisor
        if (fits) begin
          rem <= rem - dsh[56:0];
        end
        quo <= {quo[23:0], fits};
        dsh <= dsh >> 1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[tb/tb_position_tracking_velocity_controller_unit.sv]
`timescale 1ns / 1ps
module tb_position_tracking_velocity_controller_unit;

  typedef struct {
    logic               inputs_valid;
    logic [7:0]         command_age;
    logic signed [31:0] mx, my, mz, tx, ty, tz, fx, fy, fz, heading;
  } tick_t;

  typedef struct {
    logic signed [24:0] dx, dy, dz;
    logic signed [31:0] heading_out;
    logic               lost;
    logic [1:0]         mode;
  } drive_t;

  logic clk = 0;
  logic rst = 1;

  ptvc_cmd_if cmd ();
  ptvc_res_if result ();
  ptvc_cfg_if cfg ();

  position_tracking_velocity_controller_unit dut (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .result(result.source), .cfg(cfg.sink)
  );

  // predictor copy of the registers and detector state
  logic [15:0] gain_q;
  logic [23:0] limit_q, err_thr_q, slow_thr_q, severe_thr_q;
  logic [15:0] hold_ticks_q, cooldown_q, brake_ticks_q;
  logic        armed_q, hold_on_q, recovered_q;
  logic [15:0] hold_cnt_q, since_rec_q, brake_left_q;

  drive_t expected_drives[$];
  int     mismatches = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     recv_hold = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned capped_square(longint v);
    longint unsigned m;
    m = magnitude(v);
    if (m > 64'h8000_0000) m = 64'h8000_0000;
    return m * m;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void reset_controller();
    gain_q = ptvc_pkg::RST_KP_GAIN; limit_q = ptvc_pkg::RST_SPEED_LIMIT;
    err_thr_q = ptvc_pkg::RST_ERROR_THRESHOLD; slow_thr_q = ptvc_pkg::RST_LOW_SPEED_THRESH;
    severe_thr_q = ptvc_pkg::RST_SEVERE_THRESHOLD; hold_ticks_q = ptvc_pkg::RST_HOLD_TICKS;
    cooldown_q = ptvc_pkg::RST_COOLDOWN_TICKS; brake_ticks_q = ptvc_pkg::RST_BRAKE_TICKS;
    armed_q = 1; hold_on_q = 0; recovered_q = 0;
    hold_cnt_q = 0; since_rec_q = 0; brake_left_q = 0;
  endfunction

  // advance the controller by one tick and produce the expected drive
  function automatic drive_t control_tick(tick_t t);
    drive_t o;
    longint d[3], v[3], ff[3];
    longint unsigned e2, f2, thr2, n2, m, lim, a, q, p, nrm, tt;
    bit cand;
    int s;
    o = '{default: 0};
    if (hold_on_q && hold_cnt_q != ptvc_pkg::SAT16) hold_cnt_q++;
    if (recovered_q && since_rec_q != ptvc_pkg::SAT16) since_rec_q++;
    if (brake_left_q != 0) brake_left_q--;
    if (!t.inputs_valid || t.command_age > ptvc_pkg::TIMEOUT_TICKS) begin
      hold_on_q = 0; hold_cnt_q = 0;
      o.mode = ptvc_pkg::MODE_IDLE;
      return o;
    end
    d[0] = longint'(t.tx) - longint'(t.mx);
    d[1] = longint'(t.ty) - longint'(t.my);
    d[2] = longint'(t.tz) - longint'(t.mz);
    ff[0] = t.fx; ff[1] = t.fy; ff[2] = t.fz;
    e2 = 0; f2 = 0;
    for (int i = 0; i < 3; i++) begin
      e2 += capped_square(d[i]);
      f2 += capped_square(ff[i]);
    end
    thr2 = longint'(err_thr_q) * longint'(err_thr_q);
    cand = e2 > thr2 && (f2 < longint'(slow_thr_q) * longint'(slow_thr_q) ||
           e2 > longint'(severe_thr_q) * longint'(severe_thr_q));
    if (e2 <= thr2 / 4) begin
      hold_on_q = 0; hold_cnt_q = 0; armed_q = 1;
    end else if (cand && armed_q) begin
      if (!hold_on_q) begin
        hold_on_q = 1; hold_cnt_q = 0;
      end else if (hold_cnt_q >= hold_ticks_q &&
                   (!recovered_q || since_rec_q >= cooldown_q)) begin
        o.lost = 1;
        recovered_q = 1; since_rec_q = 0;
        hold_on_q = 0; hold_cnt_q = 0; armed_q = 0;
        brake_left_q = brake_ticks_q;
      end
    end else if (!cand) begin
      hold_on_q = 0; hold_cnt_q = 0;
    end
    o.heading_out = t.heading;
    if (brake_left_q != 0) begin
      o.mode = ptvc_pkg::MODE_BRAKE;
      return o;
    end
    m = 0;
    for (int i = 0; i < 3; i++) begin
      p = magnitude(d[i]) * gain_q;
      tt = (p + 128) >> 8;
      v[i] = ff[i] + (d[i] < 0 ? -longint'(tt) : longint'(tt));
      if (magnitude(v[i]) > m) m = magnitude(v[i]);
    end
    s = 0;
    while ((m >> s) >= 64'h8000_0000) s++;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      a = magnitude(v[i]) >> s;
      n2 += a * a;
    end
    lim = limit_q;
    if (s > 0 || n2 > lim * lim) begin
      nrm = floor_root(n2);
      for (int i = 0; i < 3; i++) begin
        a = magnitude(v[i]) >> s;
        q = (2 * a * lim + nrm) / (2 * nrm);
        if (q > lim) q = lim;
        v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    o.dx = v[0][24:0]; o.dy = v[1][24:0]; o.dz = v[2][24:0];
    o.mode = ptvc_pkg::MODE_TRACK;
    return o;
  endfunction

  // receiver readiness
  always @(negedge clk) begin
    if (rst) result.ready <= 0;
    else result.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    drive_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected drive item at %0t", $realtime);
      end else begin
        e = expected_drives.pop_front();
        if (result.drive_x !== e.dx || result.drive_y !== e.dy ||
            result.drive_z !== e.dz || result.heading_out !== e.heading_out ||
            result.loss_flag !== e.lost || result.mode !== e.mode) begin
          mismatches++;
          if (mismatches <= 10)
            $display("drive mismatch: exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                     e.dx, e.dy, e.dz, e.heading_out, e.lost, e.mode,
                     result.drive_x, result.drive_y, result.drive_z,
                     result.heading_out, result.loss_flag, result.mode);
        end
      end
    end
  end

  task automatic send_tick(tick_t t);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    cmd.valid <= 1;
    cmd.inputs_valid <= t.inputs_valid; cmd.command_age <= t.command_age;
    cmd.measured_x <= t.mx; cmd.measured_y <= t.my; cmd.measured_z <= t.mz;
    cmd.target_x <= t.tx; cmd.target_y <= t.ty; cmd.target_z <= t.tz;
    cmd.feedforward_x <= t.fx; cmd.feedforward_y <= t.fy; cmd.feedforward_z <= t.fz;
    cmd.heading <= t.heading;
    do @(posedge clk); while (!cmd.ready);
    expected_drives.push_back(control_tick(t));
    @(negedge clk);
    cmd.valid <= 0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_drives.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      ptvc_pkg::REG_KP_GAIN:          gain_q = val[15:0];
      ptvc_pkg::REG_SPEED_LIMIT:      limit_q = val;
      ptvc_pkg::REG_ERROR_THRESHOLD:  err_thr_q = val;
      ptvc_pkg::REG_LOW_SPEED_THRESH: slow_thr_q = val;
      ptvc_pkg::REG_SEVERE_THRESHOLD: severe_thr_q = val;
      ptvc_pkg::REG_HOLD_TICKS:       hold_ticks_q = val[15:0];
      ptvc_pkg::REG_COOLDOWN_TICKS:   cooldown_q = val[15:0];
      ptvc_pkg::REG_BRAKE_TICKS:      brake_ticks_q = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  function automatic logic signed [31:0] wide_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(262143)) - 131072;
      2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(1048575)) - 524288;
    endcase
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.inputs_valid = $urandom_range(19) != 0;
    t.command_age = $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(26));
    t.mx = wide_value(); t.my = wide_value(); t.mz = wide_value();
    t.tx = wide_value(); t.ty = wide_value(); t.tz = wide_value();
    t.fx = wide_value(); t.fy = wide_value(); t.fz = wide_value();
    t.heading = $urandom;
    return t;
  endfunction

  // small ff, error around the thresholds, so loss and braking are reached
  function automatic tick_t loss_tick(bit big);
    tick_t t;
    t = random_tick();
    t.inputs_valid = 1;
    t.command_age = $urandom_range(25);
    t.mx = $signed($urandom_range(65535)); t.my = 0; t.mz = 0;
    t.tx = t.mx + (big ? $signed($urandom_range(300000, 100000)) :
                   $signed($urandom_range(20000)));
    t.ty = $signed($urandom_range(4000)); t.tz = 0;
    t.fx = $signed($urandom_range(2000)) - 1000; t.fy = 0; t.fz = 0;
    return t;
  endfunction

  task automatic test_directed();
    tick_t t;
    t = '{default: 0};
    t.inputs_valid = 0; send_tick(t);
    t.inputs_valid = 1; t.command_age = ptvc_pkg::TIMEOUT_TICKS + 8'd1; send_tick(t);
    t.command_age = 8'hFF; send_tick(t);
    t.command_age = ptvc_pkg::TIMEOUT_TICKS; send_tick(t);
    t.command_age = 0; t.heading = 32'sh8000_0000; send_tick(t);
    t.heading = 32'sh7FFF_FFFF;
    t.mx = 32'sh8000_0000; t.tx = 32'sh7FFF_FFFF; send_tick(t);
    t.my = 32'sh7FFF_FFFF; t.ty = 32'sh8000_0000; t.fz = 32'sh8000_0000; send_tick(t);
    t = '{default: 0}; t.inputs_valid = 1;
    t.fx = 32'sh7FFF_FFFF; t.fy = 32'sh7FFF_FFFF; t.fz = 32'sh7FFF_FFFF; send_tick(t);
    t.fx = 65536; t.fy = -65536; t.fz = 0; send_tick(t);
    t.fx = 0; t.fy = 0; t.tx = 1; send_tick(t);
    t.tx = -1; send_tick(t);
    for (int i = 0; i < 14; i++) send_tick(loss_tick(i < 12));
    drain();
  endtask

  task automatic test_random(int count, bit loss_heavy);
    for (int i = 0; i < count; i++) begin
      if (loss_heavy && $urandom_range(3) != 0) send_tick(loss_tick($urandom_range(5) != 0));
      else send_tick(random_tick());
    end
    drain();
  endtask

  task automatic test_configs();
    write_reg(ptvc_pkg::REG_HOLD_TICKS, 24'd3); write_reg(ptvc_pkg::REG_COOLDOWN_TICKS, 24'd5);
    write_reg(ptvc_pkg::REG_BRAKE_TICKS, 24'd4);
    send_idle_pct = 12; recv_idle_pct = 47;
    test_random(150, 1);
    write_reg(ptvc_pkg::REG_KP_GAIN, 24'hFFFF);
    write_reg(ptvc_pkg::REG_SPEED_LIMIT, 24'hFFFFFF);
    write_reg(ptvc_pkg::REG_ERROR_THRESHOLD, 24'd0);
    write_reg(ptvc_pkg::REG_LOW_SPEED_THRESH, 24'hFFFFFF);
    write_reg(ptvc_pkg::REG_SEVERE_THRESHOLD, 24'd0);
    write_reg(ptvc_pkg::REG_HOLD_TICKS, 24'd0);
    write_reg(ptvc_pkg::REG_COOLDOWN_TICKS, 24'd0);
    write_reg(ptvc_pkg::REG_BRAKE_TICKS, 24'd0);
    send_idle_pct = 47; recv_idle_pct = 12;
    test_random(120, 0);
    write_reg(ptvc_pkg::REG_KP_GAIN, 24'd0); write_reg(ptvc_pkg::REG_SPEED_LIMIT, 24'd0);
    write_reg(ptvc_pkg::REG_ERROR_THRESHOLD, 24'hFFFFFF);
    write_reg(ptvc_pkg::REG_SEVERE_THRESHOLD, 24'hFFFFFF);
    write_reg(ptvc_pkg::REG_BRAKE_TICKS, 24'hFFFF);
    test_random(80, 0);
    write_reg(ptvc_pkg::REG_KP_GAIN, 24'd256); write_reg(ptvc_pkg::REG_SPEED_LIMIT, 24'd65536);
    write_reg(ptvc_pkg::REG_ERROR_THRESHOLD, 24'd20000);
    write_reg(ptvc_pkg::REG_LOW_SPEED_THRESH, 24'd3000);
    write_reg(ptvc_pkg::REG_SEVERE_THRESHOLD, 24'd150000);
    write_reg(ptvc_pkg::REG_HOLD_TICKS, 24'd1);
    write_reg(ptvc_pkg::REG_COOLDOWN_TICKS, 24'd2);
    write_reg(ptvc_pkg::REG_BRAKE_TICKS, 24'd2);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(230, 1);
  endtask

  // receiver stalls while the sender keeps offering items
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1;
        repeat (600) @(negedge clk);
        recv_hold = 0;
      end
      for (int i = 0; i < 40; i++) send_tick(random_tick());
    join
    drain();
  endtask

  initial begin
    reset_controller();
    cmd.valid = 0; cmd.inputs_valid = 0; cmd.command_age = 0;
    cmd.measured_x = 0; cmd.measured_y = 0; cmd.measured_z = 0;
    cmd.target_x = 0; cmd.target_y = 0; cmd.target_z = 0;
    cmd.feedforward_x = 0; cmd.feedforward_y = 0; cmd.feedforward_z = 0;
    cmd.heading = 0;
    cfg.valid = 0; cfg.index = ptvc_pkg::REG_KP_GAIN; cfg.data = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_configs();
    test_backpressure();
    drain();
    if (expected_drives.size() != 0) mismatches++;
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
